// ===== design/bpl_pkg.sv =====
// package: types and constants shared by the list cells and the top level
`timescale 1ns / 1ps
package bpl_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VAL_W    = 32;
   localparam int POS_W    = 5;

   localparam logic [VAL_W-1:0] GET_FAIL_VALUE = 32'hFFFF_FC19;

   typedef enum logic [2:0] {
      REQ_PUSH_BACK  = 3'd0,
      REQ_PUSH_FRONT = 3'd1,
      REQ_INSERT     = 3'd2,
      REQ_POP_BACK   = 3'd3,
      REQ_POP_FRONT  = 3'd4,
      REQ_DELETE     = 3'd5,
      REQ_GET        = 3'd6,
      REQ_CLEAR      = 3'd7
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_FULL   = 2'd2,
      ST_BADPOS = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2
   } cell_cmd_type;

   typedef enum logic [1:0] {
      RD_ZERO = 2'd0,
      RD_FAIL = 2'd1,
      RD_CELL = 2'd2
   } rd_mode_type;

   typedef struct packed {
      cell_cmd_type     cmd;
      logic [IDX_W-1:0] at;
      logic [VAL_W-1:0] value;
   } cell_ctrl_type;

endpackage

// ===== design/bpl_cell.sv =====
// one list cell: holds one entry, shifts toward either neighbor or loads a new value
`timescale 1ns / 1ps
module bpl_cell #(
   parameter int INDEX = 0
) (
   input  logic                        clock,
   input  bpl_pkg::cell_ctrl_type      ctrl,
   input  logic [bpl_pkg::VAL_W-1:0]   left_value,
   input  logic [bpl_pkg::VAL_W-1:0]   right_value,
   output logic [bpl_pkg::VAL_W-1:0]   value
);

   localparam logic [bpl_pkg::IDX_W-1:0] MY_INDEX = INDEX[bpl_pkg::IDX_W-1:0];

   logic [bpl_pkg::VAL_W-1:0] value_ff;
   logic [bpl_pkg::VAL_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (ctrl.cmd)
         bpl_pkg::CELL_INSERT: begin
            if (MY_INDEX == ctrl.at) begin
               value_in = ctrl.value;
            end else if (MY_INDEX > ctrl.at) begin
               value_in = left_value;
            end
         end
         bpl_pkg::CELL_REMOVE: begin
            if (MY_INDEX >= ctrl.at) begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== design/bounded_positional_list.sv =====
// top level: bounded positional list built from a row of shifting cells
`timescale 1ns / 1ps
// Ordered list of up to 16 signed 32-bit entries, entry i held in cell i. On a request
// transfer every cell shifts, loads or holds at once, so the list is updated at the
// transfer edge. The answer (status, read value, count, front and back) is formed
// from the updated cells once the output register is free and is held in that output
// register. Sustained rate is one request per cycle while the result side keeps
// up. Cell contents are not cleared by reset or by clear; only the entry count is.
module bounded_positional_list (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [39:0]   req_tdata,  // item_value[31:0], position[36:32], zero fill
   input  logic [2:0]    req_tuser,  // req_type[2:0]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [103:0]  rsp_tdata   // status[1:0], read_value[33:2], entry_count[38:34],
                                     // front_value[70:39], back_value[102:71], zero fill
);

   localparam int CAP   = bpl_pkg::CAPACITY;
   localparam int IDX_W = bpl_pkg::IDX_W;
   localparam int CNT_W = bpl_pkg::CNT_W;
   localparam int VAL_W = bpl_pkg::VAL_W;
   localparam int POS_W = bpl_pkg::POS_W;
   localparam logic [CNT_W-1:0] CAP_COUNT = CAP[CNT_W-1:0];

   logic                        req_accept;
   logic                        rsp_free;
   logic                        rsp_load;
   bpl_pkg::req_kind_type       req_kind;
   logic [VAL_W-1:0]            req_value;
   logic [POS_W-1:0]            req_pos;
   logic [CNT_W-1:0]            req_pos_ext;

   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            count_in;
   logic                        pend_ff;
   logic                        pend_in;
   bpl_pkg::status_type         pend_status_ff;
   bpl_pkg::status_type         pend_status_in;
   bpl_pkg::rd_mode_type        pend_rd_ff;
   bpl_pkg::rd_mode_type        pend_rd_in;
   logic [IDX_W-1:0]            pend_idx_ff;
   logic [IDX_W-1:0]            pend_idx_in;
   logic                        rsp_valid_ff;
   logic [103:0]                rsp_data_ff;

   bpl_pkg::cell_ctrl_type      ctrl;
   logic [VAL_W-1:0]            cell_values [CAP];

   logic [CNT_W-1:0]            back_pos;
   logic [VAL_W-1:0]            read_value;
   logic [VAL_W-1:0]            front_value;
   logic [VAL_W-1:0]            back_value;

   assign req_kind    = bpl_pkg::req_kind_type'(req_tuser);
   assign req_value   = req_tdata[31:0];
   assign req_pos     = req_tdata[36:32];
   assign req_pos_ext = CNT_W'(req_pos);

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_load   = pend_ff && rsp_free;
   assign req_tready = !pend_ff || rsp_free;
   assign req_accept = req_tvalid && req_tready;

   // request decode: cell command, new count, pending status and read selection
   always_comb begin
      ctrl.cmd       = bpl_pkg::CELL_HOLD;
      ctrl.at        = '0;
      ctrl.value     = req_value;
      count_in       = count_ff;
      pend_status_in = bpl_pkg::ST_OK;
      pend_rd_in     = bpl_pkg::RD_ZERO;
      pend_idx_in    = req_pos[IDX_W-1:0];
      if (req_accept) begin
         case (req_kind)
            bpl_pkg::REQ_PUSH_BACK, bpl_pkg::REQ_PUSH_FRONT, bpl_pkg::REQ_INSERT: begin
               if (count_ff >= CAP_COUNT) begin
                  pend_status_in = bpl_pkg::ST_FULL;
               end else begin
                  ctrl.cmd = bpl_pkg::CELL_INSERT;
                  count_in = count_ff + 1'b1;
                  if (req_kind == bpl_pkg::REQ_PUSH_FRONT) begin
                     ctrl.at = '0;
                  end else if (req_kind == bpl_pkg::REQ_INSERT && req_pos_ext < count_ff) begin
                     ctrl.at = req_pos[IDX_W-1:0];
                  end else begin
                     ctrl.at = count_ff[IDX_W-1:0];
                  end
               end
            end
            bpl_pkg::REQ_POP_BACK, bpl_pkg::REQ_POP_FRONT: begin
               if (count_ff == '0) begin
                  pend_status_in = bpl_pkg::ST_EMPTY;
               end else begin
                  ctrl.cmd = bpl_pkg::CELL_REMOVE;
                  count_in = count_ff - 1'b1;
                  if (req_kind == bpl_pkg::REQ_POP_BACK) begin
                     ctrl.at = count_in[IDX_W-1:0];
                  end else begin
                     ctrl.at = '0;
                  end
               end
            end
            bpl_pkg::REQ_DELETE: begin
               if (count_ff == '0) begin
                  pend_status_in = bpl_pkg::ST_EMPTY;
               end else if (req_pos_ext >= count_ff) begin
                  pend_status_in = bpl_pkg::ST_BADPOS;
               end else begin
                  ctrl.cmd = bpl_pkg::CELL_REMOVE;
                  ctrl.at  = req_pos[IDX_W-1:0];
                  count_in = count_ff - 1'b1;
               end
            end
            bpl_pkg::REQ_GET: begin
               if (count_ff == '0) begin
                  pend_status_in = bpl_pkg::ST_EMPTY;
                  pend_rd_in     = bpl_pkg::RD_FAIL;
               end else if (req_pos_ext >= count_ff) begin
                  pend_status_in = bpl_pkg::ST_BADPOS;
                  pend_rd_in     = bpl_pkg::RD_FAIL;
               end else begin
                  pend_rd_in = bpl_pkg::RD_CELL;
               end
            end
            default: begin
               count_in = '0;
            end
         endcase
      end
   end

   // row of cells, each fed by its neighbors
   for (genvar i = 0; i < CAP; i++) begin : g_cell
      logic [VAL_W-1:0] left_value;
      logic [VAL_W-1:0] right_value;
      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_inner_left
         assign left_value = cell_values[i-1];
      end
      if (i == CAP - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_inner_right
         assign right_value = cell_values[i+1];
      end
      bpl_cell #(
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_values[i])
      );
   end

   assign pend_in = req_accept ? 1'b1 : (rsp_load ? 1'b0 : pend_ff);

   // result fields from the updated cells
   assign back_pos    = count_ff - 1'b1;
   assign front_value = (count_ff == '0) ? '0 : cell_values[0];
   assign back_value  = (count_ff == '0) ? '0 : cell_values[back_pos[IDX_W-1:0]];

   always_comb begin
      case (pend_rd_ff)
         bpl_pkg::RD_FAIL: read_value = bpl_pkg::GET_FAIL_VALUE;
         bpl_pkg::RD_CELL: read_value = cell_values[pend_idx_ff];
         default:          read_value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= pend_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         pend_status_ff <= pend_status_in;
         pend_rd_ff     <= pend_rd_in;
         pend_idx_ff    <= pend_idx_in;
      end
      if (rsp_load) begin
         rsp_data_ff <= {1'b0, back_value, front_value, count_ff, read_value, pend_status_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_COUNT)
      else $error("entry count above capacity");

   a_accept_pending: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> pend_ff)
      else $error("accepted request left no pending result");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[1:0] == bpl_pkg::ST_EMPTY |-> rsp_data_ff[38:34] == '0)
      else $error("empty status with nonzero count");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[1:0] == bpl_pkg::ST_FULL |-> rsp_data_ff[38:34] == CAP_COUNT)
      else $error("full status below capacity");

endmodule

// ===== bench/tb.sv =====
// testbench: random and directed requests against a shadow list, results checked in order
`timescale 1ns / 1ps
module tb;
   import bpl_pkg::*;

   localparam int QUIET_LIMIT  = 400;
   localparam int RANDOM_ITEMS = 1400;
   localparam int DRAIN_CYCLES = 10;

   typedef struct {
      req_kind_type     kind;
      logic [VAL_W-1:0] value;
      logic [POS_W-1:0] position;
      int unsigned      gap;
   } list_request_type;

   typedef struct {
      status_type       status;
      logic [VAL_W-1:0] read_value;
      logic [4:0]       entry_count;
      logic [VAL_W-1:0] front_value;
      logic [VAL_W-1:0] back_value;
   } list_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [39:0]   req_tdata = '0;   // item_value[31:0], position[36:32], zero fill
   logic [2:0]    req_tuser = '0;   // req_type[2:0]
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [103:0]  rsp_tdata;        // status[1:0], read_value[33:2], entry_count[38:34],
                                    // front_value[70:39], back_value[102:71], zero fill

   list_request_type pending_requests[$];
   list_result_type  expected_results[$];
   list_request_type cur_request;

   logic [VAL_W-1:0] shadow_cells[CAPACITY];
   int               shadow_count = 0;
   int               plan_count = 0;
   int               total_requests = 0;
   int               accepted_count = 0;
   int               mismatch_count = 0;
   int               quiet_cycles = 0;
   int unsigned      gap_left = 0;
   logic             gap_armed = 1'b0;
   int unsigned      stall_left = 0;
   logic             rsp_calm = 1'b0;
   logic             req_calm = 1'b0;

   bounded_positional_list u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow list update, returns the answer the block should give
   function automatic list_result_type update_list(list_request_type rq);
      list_result_type res;
      int at;
      int i;
      res.status     = ST_OK;
      res.read_value = '0;
      case (rq.kind)
         REQ_PUSH_BACK, REQ_PUSH_FRONT, REQ_INSERT: begin
            if (shadow_count >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               if (rq.kind == REQ_PUSH_BACK) at = shadow_count;
               else if (rq.kind == REQ_PUSH_FRONT) at = 0;
               else at = int'(rq.position);
               if (at > shadow_count) at = shadow_count;
               for (i = shadow_count; i > at; i--) shadow_cells[i] = shadow_cells[i-1];
               shadow_cells[at] = rq.value;
               shadow_count++;
            end
         end
         REQ_POP_BACK, REQ_POP_FRONT, REQ_DELETE: begin
            if (rq.kind == REQ_POP_BACK) at = shadow_count - 1;
            else if (rq.kind == REQ_POP_FRONT) at = 0;
            else at = int'(rq.position);
            if (shadow_count == 0) begin
               res.status = ST_EMPTY;
            end else if (at >= shadow_count) begin
               res.status = ST_BADPOS;
            end else begin
               for (i = at; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i+1];
               shadow_count--;
            end
         end
         REQ_GET: begin
            if (shadow_count == 0) begin
               res.status     = ST_EMPTY;
               res.read_value = GET_FAIL_VALUE;
            end else if (int'(rq.position) >= shadow_count) begin
               res.status     = ST_BADPOS;
               res.read_value = GET_FAIL_VALUE;
            end else begin
               res.read_value = shadow_cells[rq.position];
            end
         end
         default: begin
            shadow_count = 0;
         end
      endcase
      res.entry_count = shadow_count[4:0];
      if (shadow_count == 0) begin
         res.front_value = '0;
         res.back_value  = '0;
      end else begin
         res.front_value = shadow_cells[0];
         res.back_value  = shadow_cells[shadow_count-1];
      end
      return res;
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         4:       return GET_FAIL_VALUE;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_position();
      if ($urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, 31));
      return POS_W'($urandom_range(0, plan_count));
   endfunction

   // queue a request and track the count it leaves behind
   task automatic add_request(req_kind_type kind, logic [VAL_W-1:0] value,
                              logic [POS_W-1:0] position);
      list_request_type rq;
      rq.kind     = kind;
      rq.value    = value;
      rq.position = position;
      rq.gap      = req_calm ? 0 : $urandom_range(0, 9);
      pending_requests.push_back(rq);
      case (kind)
         REQ_PUSH_BACK, REQ_PUSH_FRONT, REQ_INSERT:
            if (plan_count < CAPACITY) plan_count++;
         REQ_POP_BACK, REQ_POP_FRONT:
            if (plan_count > 0) plan_count--;
         REQ_DELETE:
            if (plan_count > 0 && int'(position) < plan_count) plan_count--;
         REQ_CLEAR:
            plan_count = 0;
         default: ;
      endcase
   endtask

   task automatic compare_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
         mismatch_count++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      logic nxt_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_armed = 1'b0;
      end else begin
         nxt_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            expected_results.push_back(update_list(cur_request));
            accepted_count++;
            nxt_valid = 1'b0;
         end
         if (!nxt_valid && pending_requests.size() != 0) begin
            if (!gap_armed) begin
               gap_left  = pending_requests[0].gap;
               gap_armed = 1'b1;
            end
            if (gap_left == 0) begin
               cur_request = pending_requests.pop_front();
               gap_armed   = 1'b0;
               req_tuser <= cur_request.kind;
               req_tdata <= {3'b000, cur_request.position, cur_request.value};
               nxt_valid = 1'b1;
            end else begin
               gap_left--;
            end
         end
         req_tvalid <= nxt_valid;
      end
   end

   // monitor
   always @(posedge clock) begin
      logic nxt_ready;
      list_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 9);
      end else begin
         nxt_ready = rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("result transfer with no request outstanding");
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_tdata[1:0]));
               compare_field("read_value", want.read_value, rsp_tdata[33:2]);
               compare_field("entry_count", 32'(want.entry_count), 32'(rsp_tdata[38:34]));
               compare_field("front_value", want.front_value, rsp_tdata[70:39]);
               compare_field("back_value", want.back_value, rsp_tdata[102:71]);
            end
            if ($urandom_range(0, 63) == 0) rsp_calm = !rsp_calm;
            stall_left = rsp_calm ? 0 : $urandom_range(0, 9);
            nxt_ready  = (stall_left == 0);
         end else if (!rsp_tready) begin
            if (stall_left == 0) nxt_ready = 1'b1;
            else stall_left--;
         end
         rsp_tready <= nxt_ready;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      int phase;
      int phase_len;
      int roll;
      int i;
      req_kind_type kind;

      // empty list cases
      add_request(REQ_POP_BACK, pick_value(), 5'd0);
      add_request(REQ_POP_FRONT, pick_value(), 5'd0);
      add_request(REQ_DELETE, pick_value(), 5'd0);
      add_request(REQ_GET, pick_value(), 5'd0);
      // insert into empty, append past the end, front and back pushes
      add_request(REQ_INSERT, 32'h7FFF_FFFF, 5'd0);
      add_request(REQ_INSERT, 32'h8000_0000, 5'd31);
      add_request(REQ_PUSH_FRONT, 32'h0000_0000, 5'd0);
      add_request(REQ_PUSH_BACK, 32'hFFFF_FFFF, 5'd0);
      add_request(REQ_INSERT, pick_value(), 5'd0);
      add_request(REQ_INSERT, pick_value(), 5'd2);
      for (i = 0; i < 10; i++)
         add_request((i % 2) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, pick_value(), 5'd0);
      // full list
      add_request(REQ_PUSH_BACK, pick_value(), 5'd0);
      add_request(REQ_PUSH_FRONT, pick_value(), 5'd0);
      add_request(REQ_INSERT, pick_value(), 5'd16);
      add_request(REQ_GET, pick_value(), 5'd15);
      add_request(REQ_GET, pick_value(), 5'd16);
      // delete of the last entry, then past the end
      add_request(REQ_DELETE, pick_value(), 5'd15);
      add_request(REQ_DELETE, pick_value(), 5'd20);
      add_request(REQ_POP_FRONT, pick_value(), 5'd0);
      add_request(REQ_POP_BACK, pick_value(), 5'd0);
      add_request(REQ_CLEAR, pick_value(), 5'd0);
      add_request(REQ_GET, pick_value(), 5'd0);

      i = pending_requests.size();
      while (pending_requests.size() < i + RANDOM_ITEMS) begin
         phase     = $urandom_range(0, 3);
         phase_len = $urandom_range(20, 80);
         req_calm  = ($urandom_range(0, 3) == 0);
         repeat (phase_len) begin
            roll = $urandom_range(0, 9);
            case (phase)
               0: begin
                  if (roll < 3) kind = REQ_PUSH_BACK;
                  else if (roll < 5) kind = REQ_PUSH_FRONT;
                  else if (roll < 8) kind = REQ_INSERT;
                  else if (roll < 9) kind = REQ_GET;
                  else kind = REQ_POP_FRONT;
               end
               1: begin
                  if (roll < 2) kind = REQ_POP_BACK;
                  else if (roll < 4) kind = REQ_POP_FRONT;
                  else if (roll < 7) kind = REQ_DELETE;
                  else if (roll < 9) kind = REQ_GET;
                  else kind = REQ_PUSH_BACK;
               end
               2: begin
                  kind = req_kind_type'($urandom_range(0, 7));
                  if (kind == REQ_CLEAR && $urandom_range(0, 3) != 0) kind = REQ_GET;
               end
               default: begin
                  // hover around a full list
                  if (plan_count < CAPACITY - 1) kind = (roll < 5) ? REQ_INSERT : REQ_PUSH_BACK;
                  else if (roll < 3) kind = REQ_DELETE;
                  else if (roll < 6) kind = REQ_INSERT;
                  else if (roll < 8) kind = REQ_GET;
                  else kind = REQ_PUSH_FRONT;
               end
            endcase
            add_request(kind, pick_value(), pick_position());
         end
      end
      total_requests = pending_requests.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (accepted_count < total_requests || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
